// File: sv/spdr_pkg.sv
// shared types, constants and sigmoid table generation for the sigmoid perceptron
`default_nettype none
package spdr_pkg;

    localparam int VALUE_BITS      = 16;
    localparam int FRAC_BITS       = 12;
    localparam int TAB_DEPTH       = 256;
    localparam int TAB_BITS        = $clog2(TAB_DEPTH);
    localparam int ACT_BITS        = 13;
    localparam int MAX_INPUTS_DEF  = 16;
    localparam int MAX_OUTPUTS_DEF = 8;
    localparam int MUL_BITS        = 24;
    localparam int PROD_BITS       = 2 * MUL_BITS;

    localparam logic [ACT_BITS-1:0] ACT_ONE = ACT_BITS'(4096);

    localparam logic [1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [1:0] KIND_FEATURE = 2'd1;
    localparam logic [1:0] KIND_TARGET  = 2'd2;

    localparam logic RES_ACT  = 1'b0;
    localparam logic RES_DONE = 1'b1;

    localparam logic [1:0] CFG_RATE    = 2'd0;
    localparam logic [1:0] CFG_INPUTS  = 2'd1;
    localparam logic [1:0] CFG_OUTPUTS = 2'd2;

    localparam logic [15:0] RATE_RESET = 16'd6554;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         index;
        logic signed [15:0] value;
        logic               last;
        logic               train;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [2:0]         node;
        logic [ACT_BITS-1:0] activation;
        logic               last_result;
    } t_out_item;

    typedef logic [TAB_DEPTH-1:0][ACT_BITS-1:0] t_sig_tab;

    // saturate a wide signed value to the value width
    function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd32767;
        lo = -48'sd32768;
        if (v > hi) begin
            return VALUE_BITS'(hi);
        end else if (v < lo) begin
            return VALUE_BITS'(lo);
        end
        return VALUE_BITS'(v);
    endfunction

    // restoring divide, only used while building the table at elaboration
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // e^-f in q30, f in [0, 1]
    function automatic longint unsigned exp_neg_q30(input longint unsigned f);
        longint unsigned sum;
        longint unsigned term;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 20; k++) begin
            term = udiv((term * f) >> 30, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [ACT_BITS-1:0] sigmoid_q12(input longint x);
        longint unsigned t;
        longint unsigned n;
        longint unsigned e;
        longint unsigned e1;
        longint unsigned den;
        longint unsigned r;
        t = (x < 0) ? 64'(-x) : 64'(x);
        n = t >> FRAC_BITS;
        e = 0;
        if (n < 16) begin
            e1 = exp_neg_q30(64'd1 << 30);
            e  = exp_neg_q30((t & 64'd4095) << 18);
            for (int i = 0; i < 16; i++) begin
                if (64'(i) < n) begin
                    e = (e * e1) >> 30;
                end
            end
        end
        den = (64'd1 << 30) + e;
        if (x >= 0) begin
            r = udiv((64'd1 << 42) + (den >> 1), den);
        end else begin
            r = udiv(64'd4096 * e + (den >> 1), den);
        end
        return ACT_BITS'(r);
    endfunction

    // bucket midpoints over the whole signed value range
    function automatic t_sig_tab sig_table();
        t_sig_tab        tab;
        longint unsigned off;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            off = (64'(2 * i + 1) << VALUE_BITS) >> (TAB_BITS + 1);
            tab[i] = sigmoid_q12(longint'(off) - (64'sd1 <<< (VALUE_BITS - 1)));
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

// File: sv/spdr_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module spdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/sigmoid_perceptron_delta_rule.sv
// single-layer sigmoid perceptron with online delta-rule weight training
//
// Input channel (i_in_valid / o_in_stall) carries weight writes, feature elements
// and target elements; one transfer each. Weight writes and non-final elements are
// taken in idle. A final feature without train runs inference: per node, a read,
// multiply and accumulate step for each input through the one shared 24x24
// multiplier and the weight ram read port, then one activation result. A final
// awaited target runs inference plus update: per node the same accumulation and
// gradient steps, then a read-modify-write for each input on the weight ram, then
// one done result at the end. The input is stalled while the sequencer is busy.
// Output channel (o_out_valid / i_out_stall) has one output register; when the
// receiver stalls, the sequencer holds before loading the next result, and the
// last result of an item may wait there while the next input item is taken.
// Reset (synchronous, active low) clears the wait-for-targets flag, the output
// valid and the configuration registers; weights, features and targets stay
// undefined until written. Configuration is written through i_cfg_we.
`default_nettype none
module sigmoid_perceptron_delta_rule #(
    parameter int MAX_INPUTS  = spdr_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = spdr_pkg::MAX_OUTPUTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire spdr_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output spdr_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import spdr_pkg::*;

    localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;
    localparam int ADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int FI_W   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NO_W   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int NI_W   = $clog2(MAX_INPUTS + 1);
    localparam int NOC_W  = $clog2(MAX_OUTPUTS + 1);
    localparam int ACC_W  = 2 * VALUE_BITS + $clog2(MAX_INPUTS + 1) + 1;
    localparam t_sig_tab SIG_TAB = sig_table();

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_RD   = 14'b00000000000010,
        ST_MUL  = 14'b00000000000100,
        ST_ACC  = 14'b00000000001000,
        ST_ACT  = 14'b00000000010000,
        ST_EMIT = 14'b00000000100000,
        ST_G1   = 14'b00000001000000,
        ST_G2   = 14'b00000010000000,
        ST_G3   = 14'b00000100000000,
        ST_URD  = 14'b00001000000000,
        ST_UX   = 14'b00010000000000,
        ST_UL   = 14'b00100000000000,
        ST_UW   = 14'b01000000000000,
        ST_DONE = 14'b10000000000000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_await, n_await;
    logic                       r_train, n_train;
    logic [15:0]                r_lr;
    logic [NI_W-1:0]            r_ni;
    logic [NOC_W-1:0]           r_no;
    logic signed [VALUE_BITS-1:0] r_feat [MAX_INPUTS];
    logic signed [VALUE_BITS-1:0] r_tgt  [MAX_OUTPUTS];
    logic [NO_W-1:0]            r_node, n_node;
    logic [ADDR_W-1:0]          r_base, n_base;
    logic [FI_W-1:0]            r_j, n_j;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [PROD_BITS-1:0] r_prod, n_prod;
    logic [ACT_BITS-1:0]        r_act, n_act;
    logic signed [VALUE_BITS-1:0] r_g, n_g;
    logic signed [VALUE_BITS-1:0] r_w, n_w;
    t_out_item                  r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    logic                       in_take;
    logic                       out_take;
    logic                       out_free;
    logic                       feat_we;
    logic                       tgt_we;
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [VALUE_BITS-1:0]      ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [VALUE_BITS-1:0]      ram_rdata;
    logic signed [MUL_BITS-1:0] m_a, m_b;
    logic signed [PROD_BITS-1:0] m_p;
    logic signed [VALUE_BITS-1:0] feat_j;
    logic signed [VALUE_BITS-1:0] sum_sat;
    logic [VALUE_BITS-1:0]      sum_u;
    logic signed [17:0]         err;
    logic signed [47:0]         diff;
    logic                       j_end;
    logic                       node_end;

    spdr_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (WDEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || out_take;

    assign feat_j   = r_feat[r_j];
    assign j_end    = (r_j == FI_W'(r_ni - NI_W'(1)));
    assign node_end = (r_node == NO_W'(r_no - NOC_W'(1)));
    assign ram_raddr = ADDR_W'(r_base + ADDR_W'(r_j));

    assign feat_we = in_take && i_in_item.kind == KIND_FEATURE
                     && int'(i_in_item.index) < MAX_INPUTS;
    assign tgt_we  = in_take && i_in_item.kind == KIND_TARGET
                     && int'(i_in_item.index) < MAX_OUTPUTS;

    // sum to table index: floor shift, saturate, offset by the minimum
    assign sum_sat = sat_val(48'($signed(r_acc[ACC_W-1:FRAC_BITS])));
    assign sum_u   = sum_sat ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
    assign err     = $signed({5'b0, r_act}) - 18'(r_tgt[r_node]);
    assign diff    = 48'(r_w) - 48'($signed(r_prod[47:16]));

    // shared multiplier operand selection
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_MUL: begin
                m_a = MUL_BITS'($signed(ram_rdata));
                m_b = MUL_BITS'(feat_j);
            end
            ST_G1: begin
                m_a = $signed({11'b0, r_act});
                m_b = $signed({11'b0, ACT_BITS'(ACT_ONE - r_act)});
            end
            ST_G2: begin
                m_a = MUL_BITS'(err);
                m_b = $signed({1'b0, r_prod[22:0]});
            end
            ST_UX: begin
                m_a = MUL_BITS'(r_g);
                m_b = MUL_BITS'(feat_j);
            end
            ST_UL: begin
                m_a = MUL_BITS'($signed(r_prod[31:12]));
                m_b = $signed({8'b0, r_lr});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    always_comb begin
        n_state     = r_state;
        n_await     = r_await;
        n_train     = r_train;
        n_node      = r_node;
        n_base      = r_base;
        n_j         = r_j;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_act       = r_act;
        n_g         = r_g;
        n_w         = r_w;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_take;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(i_in_item.index);
        ram_wdata   = i_in_item.value;

        case (r_state)
            ST_IDLE: begin
                n_node = '0;
                n_base = '0;
                n_j    = '0;
                n_acc  = '0;
                if (in_take) begin
                    case (i_in_item.kind)
                        KIND_WEIGHT: begin
                            ram_we = int'(i_in_item.index) < WDEPTH;
                        end
                        KIND_FEATURE: begin
                            if (i_in_item.last) begin
                                n_await = i_in_item.train;
                                if (!i_in_item.train) begin
                                    n_train = 1'b0;
                                    n_state = ST_RD;
                                end
                            end
                        end
                        KIND_TARGET: begin
                            if (i_in_item.last && r_await) begin
                                n_await = 1'b0;
                                n_train = 1'b1;
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = m_p;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc = r_acc + ACC_W'($signed(r_prod[31:0]));
                if (j_end) begin
                    n_state = ST_ACT;
                end else begin
                    n_j     = r_j + FI_W'(1);
                    n_state = ST_RD;
                end
            end
            ST_ACT: begin
                n_act   = SIG_TAB[sum_u[VALUE_BITS-1 -: TAB_BITS]];
                n_state = r_train ? ST_G1 : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = RES_ACT;
                    n_out.node        = 3'(r_node);
                    n_out.activation  = r_act;
                    n_out.last_result = node_end;
                    n_node            = r_node + NO_W'(1);
                    n_base            = ADDR_W'(r_base + ADDR_W'(r_ni));
                    n_j               = '0;
                    n_acc             = '0;
                    n_state           = node_end ? ST_IDLE : ST_RD;
                end
            end
            ST_G1: begin
                n_prod  = m_p;
                n_state = ST_G2;
            end
            ST_G2: begin
                n_prod  = m_p;
                n_state = ST_G3;
            end
            ST_G3: begin
                n_g     = sat_val(48'($signed(r_prod[47:24])));
                n_j     = '0;
                n_state = ST_URD;
            end
            ST_URD: begin
                n_state = ST_UX;
            end
            ST_UX: begin
                n_w     = $signed(ram_rdata);
                n_prod  = m_p;
                n_state = ST_UL;
            end
            ST_UL: begin
                n_prod  = m_p;
                n_state = ST_UW;
            end
            ST_UW: begin
                ram_we    = 1'b1;
                ram_waddr = ram_raddr;
                ram_wdata = sat_val(diff);
                if (!j_end) begin
                    n_j     = r_j + FI_W'(1);
                    n_state = ST_URD;
                end else if (node_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_node  = r_node + NO_W'(1);
                    n_base  = ADDR_W'(r_base + ADDR_W'(r_ni));
                    n_j     = '0;
                    n_acc   = '0;
                    n_state = ST_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = RES_DONE;
                    n_out.node        = '0;
                    n_out.activation  = '0;
                    n_out.last_result = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_await     <= 1'b0;
            r_out_valid <= 1'b0;
            r_lr        <= RATE_RESET;
            r_ni        <= NI_W'((MAX_INPUTS < 16) ? MAX_INPUTS : 16);
            r_no        <= NOC_W'((MAX_OUTPUTS < 8) ? MAX_OUTPUTS : 8);
        end else begin
            r_state     <= n_state;
            r_await     <= n_await;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE: begin
                        r_lr <= i_cfg_data;
                    end
                    CFG_INPUTS: begin
                        if (i_cfg_data == '0) begin
                            r_ni <= NI_W'(1);
                        end else if (int'(i_cfg_data) > MAX_INPUTS) begin
                            r_ni <= NI_W'(MAX_INPUTS);
                        end else begin
                            r_ni <= NI_W'(i_cfg_data);
                        end
                    end
                    CFG_OUTPUTS: begin
                        if (i_cfg_data == '0) begin
                            r_no <= NOC_W'(1);
                        end else if (int'(i_cfg_data) > MAX_OUTPUTS) begin
                            r_no <= NOC_W'(MAX_OUTPUTS);
                        end else begin
                            r_no <= NOC_W'(i_cfg_data);
                        end
                    end
                    default: begin
                        r_lr <= r_lr;
                    end
                endcase
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_train <= n_train;
        r_node  <= n_node;
        r_base  <= n_base;
        r_j     <= n_j;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_act   <= n_act;
        r_g     <= n_g;
        r_w     <= n_w;
        r_out   <= n_out;
        if (feat_we) begin
            r_feat[FI_W'(i_in_item.index)] <= i_in_item.value;
        end
        if (tgt_we) begin
            r_tgt[NO_W'(i_in_item.index)] <= i_in_item.value;
        end
    end
endmodule
`default_nettype wire

// File: tb/sigmoid_perceptron_delta_rule_test.sv
// self-checking testbench for the sigmoid perceptron with delta-rule training
`timescale 1ns / 100ps
module sigmoid_perceptron_delta_rule_test;
    import spdr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         N_WEIGHTS   = MAX_INPUTS_DEF * MAX_OUTPUTS_DEF;
    localparam int         SETTLE      = 1200;
    localparam longint     CYCLE_LIMIT = 3000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_item   i_in_item;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       i_out_stall;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    sigmoid_perceptron_delta_rule dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_item(o_out_item), .i_out_stall(i_out_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // perceptron state as the block should hold it
    logic signed [15:0] weight_mem [N_WEIGHTS];
    logic signed [15:0] feature_mem [MAX_INPUTS_DEF];
    logic signed [15:0] target_mem [MAX_OUTPUTS_DEF];
    bit                 waiting_for_targets;
    int                 step_rate;
    int                 n_inputs;
    int                 n_outputs;
    logic [ACT_BITS-1:0] sigmoid_lut [TAB_DEPTH];

    t_out_item pending_results[$];
    int        mismatches;
    int        sender_idle_pct;
    int        receiver_stall_pct;
    longint    cycle_count;

    initial begin
        i_clk = 1'b0;
        cycle_count = 0;
        forever begin
            #5 i_clk = ~i_clk;
            if (i_clk) begin
                cycle_count++;
                if (cycle_count > CYCLE_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // e^-f with 30 fraction bits, f in [0, 1]
    function automatic longint unsigned exp_minus(input longint unsigned f);
        longint unsigned acc;
        longint unsigned term;
        acc = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * f) >> 30) / longint'(k);
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    function automatic logic [ACT_BITS-1:0] logistic(input longint x);
        longint unsigned mag;
        longint unsigned whole;
        longint unsigned ex;
        longint unsigned e_one;
        longint unsigned den;
        mag = (x < 0) ? -x : x;
        whole = mag >> 12;
        ex = 0;
        if (whole < 16) begin
            e_one = exp_minus(64'd1 << 30);
            ex = exp_minus((mag & 64'd4095) << 18);
            for (longint unsigned i = 0; i < whole; i++) ex = (ex * e_one) >> 30;
        end
        den = (64'd1 << 30) + ex;
        if (x >= 0) return ACT_BITS'(((64'd1 << 42) + den / 2) / den);
        return ACT_BITS'((64'd4096 * ex + den / 2) / den);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [ACT_BITS-1:0] node_activation(input int node);
        longint acc;
        longint s;
        acc = 0;
        for (int j = 0; j < n_inputs; j++)
            acc += longint'(weight_mem[node * n_inputs + j]) * longint'(feature_mem[j]);
        s = clip(acc >>> 12, -32768, 32767);
        return sigmoid_lut[(s + 32768) >> 8];
    endfunction

    function automatic void delta_rule_update();
        logic [ACT_BITS-1:0] act [MAX_OUTPUTS_DEF];
        longint out_v;
        longint grad;
        longint prod;
        longint delta;
        int     w;
        for (int o = 0; o < n_outputs; o++) act[o] = node_activation(o);
        for (int o = 0; o < n_outputs; o++) begin
            out_v = act[o];
            grad = clip(((out_v - longint'(target_mem[o])) * (out_v * (4096 - out_v))) >>> 24,
                        -32768, 32767);
            for (int j = 0; j < n_inputs; j++) begin
                w = o * n_inputs + j;
                prod = clip((grad * longint'(feature_mem[j])) >>> 12,
                            -(64'sd1 << 46), 64'sd1 << 46);
                delta = (prod * longint'(step_rate)) >>> 16;
                weight_mem[w] = 16'(clip(longint'(weight_mem[w]) - delta, -32768, 32767));
            end
        end
    endfunction

    // update the state for one accepted transfer and queue what it causes
    function automatic void predict_results(input t_in_item it);
        t_out_item r;
        case (it.kind)
            KIND_WEIGHT: if (it.index < N_WEIGHTS) weight_mem[it.index] = it.value;
            KIND_FEATURE: begin
                if (it.index < MAX_INPUTS_DEF) feature_mem[it.index] = it.value;
                if (it.last) begin
                    waiting_for_targets = it.train;
                    if (!it.train) begin
                        for (int o = 0; o < n_outputs; o++) begin
                            r.result_kind = RES_ACT;
                            r.node = 3'(o);
                            r.activation = node_activation(o);
                            r.last_result = (o + 1 == n_outputs);
                            pending_results = {pending_results, r};
                        end
                    end
                end
            end
            KIND_TARGET: begin
                if (it.index < MAX_OUTPUTS_DEF) target_mem[it.index] = it.value;
                if (it.last && waiting_for_targets) begin
                    delta_rule_update();
                    waiting_for_targets = 0;
                    r.result_kind = RES_DONE;
                    r.node = '0;
                    r.activation = '0;
                    r.last_result = 1'b1;
                    pending_results = {pending_results, r};
                end
            end
            default: ;
        endcase
    endfunction

    // result side: random stall and compare every transfer
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result mismatch: expected %p got %p",
                                                   want, o_out_item);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_results(it);
    endtask

    task automatic send(input logic [1:0] kind, input int index, input int value,
                        input bit last = 0, input bit train = 0);
        t_in_item it;
        it.kind = kind;
        it.index = 7'(index);
        it.value = 16'(value);
        it.last = last;
        it.train = train;
        send_item(it);
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input int data);
        wait_until_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 16'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RATE:    step_rate = data & 16'hFFFF;
            CFG_INPUTS:  n_inputs = int'(clip(data, 1, MAX_INPUTS_DEF));
            CFG_OUTPUTS: n_outputs = int'(clip(data, 1, MAX_OUTPUTS_DEF));
            default: ;
        endcase
    endtask

    task automatic send_sample(input bit train, input int feat_span, input int tgt_lo,
                               input int tgt_hi);
        for (int j = 0; j < n_inputs; j++)
            send(KIND_FEATURE, j, $urandom_range(2 * feat_span) - feat_span,
                 j == n_inputs - 1, train);
        if (train)
            for (int o = 0; o < n_outputs; o++)
                send(KIND_TARGET, o, $urandom_range(tgt_hi - tgt_lo) + tgt_lo,
                     o == n_outputs - 1);
    endtask

    // every store entry gets a value before anything reads it
    task automatic test_fill_stores();
        for (int w = 0; w < N_WEIGHTS; w++)
            send(KIND_WEIGHT, w, (w == 0) ? 32767 : ((w == 1) ? -32768 : $urandom_range(8191) - 4096));
        for (int j = 0; j < MAX_INPUTS_DEF; j++) send(KIND_FEATURE, j, $urandom_range(8191) - 4096);
        for (int o = 0; o < MAX_OUTPUTS_DEF; o++) send(KIND_TARGET, o, $urandom_range(4096));
    endtask

    task automatic test_inference_extremes();
        send(KIND_FEATURE, 0, 32767);
        send(KIND_FEATURE, 1, -32768);
        send(KIND_FEATURE, 15, 0, 1, 0);
        for (int j = 0; j < MAX_INPUTS_DEF; j++) send(KIND_FEATURE, j, 32767, j == 15);
        for (int j = 0; j < MAX_INPUTS_DEF; j++) send(KIND_FEATURE, j, -32768, j == 15);
    endtask

    task automatic test_training();
        send_sample(1, 4096, 0, 4096);
        send_sample(1, 32767, -32768, 32767);
        send_sample(0, 4096, 0, 0);
    endtask

    task automatic test_corner_items();
        send(KIND_WEIGHT, 127, 100);
        send(KIND_FEATURE, 16, 1234, 1, 0);     // out-of-range feature, last still acts
        send(KIND_TARGET, 8, 555, 1);           // out-of-range target, not awaited
        send(KIND_UNUSED, 127, -1, 1, 1);
        send(KIND_TARGET, 3, 2048, 1);          // final target with nothing awaited
        send(KIND_FEATURE, 127, 0, 1, 1);       // arm training
        send(KIND_WEIGHT, 200 - 128, -500);     // weight write while armed
        send(KIND_FEATURE, 2, 77, 1, 1);        // final feature while armed re-arms
        send(KIND_FEATURE, 2, 77, 1, 0);        // and now clears with inference
        send(KIND_TARGET, 0, 4096, 1);          // no longer awaited
        send(KIND_FEATURE, 5, -9, 1, 1);
        send(KIND_TARGET, 127, 1, 1);           // out-of-range index still trains
        send(KIND_WEIGHT, 127, 0);
    endtask

    task automatic test_register_settings();
        write_register(CFG_RATE, 65535);
        write_register(CFG_INPUTS, 1);
        write_register(CFG_OUTPUTS, 1);
        send_sample(1, 4096, 0, 4096);
        send_sample(0, 4096, 0, 0);
        write_register(CFG_RATE, 0);
        write_register(CFG_INPUTS, 0);
        write_register(CFG_OUTPUTS, 15);
        send_sample(1, 4096, 0, 4096);
        send_sample(0, 4096, 0, 0);
        write_register(CFG_INPUTS, 31);
        write_register(CFG_OUTPUTS, 0);
        write_register(CFG_RATE, 6554);
        send_sample(1, 8192, 0, 4096);
        write_register(CFG_OUTPUTS, 8);
        write_register(CFG_INPUTS, 16);
    endtask

    task automatic random_noise_item();
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'($urandom));
        if (it.kind == KIND_FEATURE && it.last && !it.train && $urandom_range(1)) it.last = 0;
        send_item(it);
    endtask

    task automatic test_random_traffic();
        int idle_pct [4] = '{0, 86, 0, 36};
        int stall_pct [4] = '{0, 0, 86, 36};
        int sent;
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_pct[ph];
            receiver_stall_pct = stall_pct[ph];
            case (ph)
                1: write_register(CFG_INPUTS, $urandom_range(2, 15));
                2: write_register(CFG_OUTPUTS, $urandom_range(2, 7));
                3: write_register(CFG_RATE, $urandom_range(65535));
                default: ;
            endcase
            sent = 0;
            while (sent < 8) begin
                case ($urandom_range(9))
                    0: begin
                        random_noise_item();
                        sent++;
                    end
                    1: begin
                        send(KIND_WEIGHT, $urandom_range(N_WEIGHTS - 1),
                             $urandom_range(8191) - 4096);
                        sent++;
                    end
                    2, 3, 4: begin
                        send_sample(0, $urandom_range(1) ? 4096 : 32767, 0, 0);
                        sent += n_inputs;
                    end
                    default: begin
                        send_sample(1, $urandom_range(1) ? 4096 : 32767,
                                    $urandom_range(3) == 0 ? -32768 : 0,
                                    $urandom_range(3) == 0 ? 32767 : 4096);
                        sent += n_inputs + n_outputs;
                    end
                endcase
                if (ph == 1 && sent > 0 && sent < 8) wait_until_drained();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_RATE;
        i_cfg_data = '0;
        mismatches = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        waiting_for_targets = 0;
        step_rate = RATE_RESET;
        n_inputs = MAX_INPUTS_DEF;
        n_outputs = MAX_OUTPUTS_DEF;
        for (int i = 0; i < TAB_DEPTH; i++)
            sigmoid_lut[i] = logistic(longint'(((2 * i + 1) << 16) / 512) - 32768);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_stores();
        test_inference_extremes();
        test_training();
        test_corner_items();
        test_register_settings();
        test_random_traffic();

        wait_until_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/spdr_pkg.sv
sv/spdr_ram.sv
sv/sigmoid_perceptron_delta_rule.sv
tb/sigmoid_perceptron_delta_rule_test.sv
